// ===== sv/mmh_pkg.sv =====
package mmh_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEN_W   = 32;

  // Mask that keeps the lowest nbytes bytes of a word.
  function automatic logic [63:0] low_bytes_mask(input logic [2:0] nbytes);
    logic [63:0] mask;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, nbytes}) begin
        mask[8*i +: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

  // One shift-xor step of the mixer.
  function automatic logic [63:0] shift_xor(input logic [63:0] value);
    return value ^ (value >> MIX_SHIFT);
  endfunction

endpackage

// ===== sv/mmh_mul.sv =====
module mmh_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a_in,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [1:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod_w;

  // The low 64 bits of the product need three 32-bit partial products.
  always_comb begin
    case (cnt_r)
      2'd0: begin
        mul_x = a_r[31:0];
        mul_y = mmh_pkg::MIX_MUL[31:0];
      end
      2'd1: begin
        mul_x = a_r[63:32];
        mul_y = mmh_pkg::MIX_MUL[31:0];
      end
      default: begin
        mul_x = a_r[31:0];
        mul_y = mmh_pkg::MIX_MUL[63:32];
      end
    endcase
  end

  assign prod_w = {32'h0, mul_x} * {32'h0, mul_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a_in;
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        prod_r <= prod_w;
        case (cnt_r) inside
          2'd1: acc_r <= prod_r;
          2'd2, 2'd3: acc_r <= acc_r + {prod_r[31:0], 32'h0};
          default: acc_r <= acc_r;
        endcase
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ===== sv/murmur64a_hash_stream_top.sv =====
// Channel  Direction  Ports                     Contents
// in       slave      in_tvalid/tready/tdata    tdata: data_word, byte_count, message_length
//                     in_tuser, in_tlast        tuser: first_word; tlast: last_word
// out      master     out_tvalid/tready/tdata   tdata: hash_value
// cfg      write      cfg_wr_en, cfg_wr_data    hash_seed
//
// All 64-bit multiplies go through one shared unit.
// Each word issues its multiplies in turn: one for a first word, three for a full word,
// one for a partial word and one for a last word. The input is not ready until the
// current word is finished.
// A finished hash waits in the output register, so the next word can be accepted
// while it is still held. Reset clears the seed and the running hash.
module murmur64a_hash_stream_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,    // data_word[63:0], byte_count[67:64],
                                    // message_length[99:68], zero fill
  input  logic         in_tuser,    // first_word
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // hash_value
  input  logic         cfg_wr_en,
  input  logic [63:0]  cfg_wr_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LEN,
    S_FOLD,
    S_K1,
    S_K2,
    S_H,
    S_END,
    S_FIN,
    S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] op_r, op_nxt;
  logic        start_r, start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        first_r;
  logic        last_r;
  logic [31:0] len_r;
  logic        mul_done;
  logic [63:0] mul_res;
  logic [63:0] fin_w;
  logic        out_free;

  mmh_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .a_in   (op_r),
    .done   (mul_done),
    .result (mul_res)
  );

  assign fin_w    = mmh_pkg::shift_xor(mul_res);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    op_nxt        = op_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (first_r) begin
          op_nxt    = {32'h0, len_r};
          start_nxt = 1'b1;
          state_nxt = S_LEN;
        end else begin
          state_nxt = S_FOLD;
        end
      end
      S_LEN: begin
        if (mul_done) begin
          hash_nxt  = seed_r ^ mul_res;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (cnt_r[3]) begin
          op_nxt    = word_r;
          start_nxt = 1'b1;
          state_nxt = S_K1;
        end else if (cnt_r[2:0] != 3'd0) begin
          op_nxt    = hash_r ^ (word_r & mmh_pkg::low_bytes_mask(cnt_r[2:0]));
          start_nxt = 1'b1;
          state_nxt = S_H;
        end else begin
          state_nxt = S_END;
        end
      end
      S_K1: begin
        if (mul_done) begin
          op_nxt    = mmh_pkg::shift_xor(mul_res);
          start_nxt = 1'b1;
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        if (mul_done) begin
          op_nxt    = hash_r ^ mul_res;
          start_nxt = 1'b1;
          state_nxt = S_H;
        end
      end
      S_H: begin
        if (mul_done) begin
          hash_nxt  = mul_res;
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (last_r) begin
          op_nxt    = mmh_pkg::shift_xor(hash_r);
          start_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (mul_done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = fin_w;
            state_nxt     = S_IDLE;
          end else begin
            op_nxt    = fin_w;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = op_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 64'h0;
      hash_r      <= 64'h0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      op_r        <= op_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (state_r == S_IDLE && in_tvalid) begin
        word_r  <= in_tdata[63:0];
        cnt_r   <= in_tdata[67:64];
        len_r   <= in_tdata[99:68];
        first_r <= in_tuser;
        last_r  <= in_tlast;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
